/* rtl/core/wsd_pkg.sv */
// ----------------------------------------------------------------------------
// wsd_pkg: shared types and constants
// Parse phases, error codes, tags and the result struct of the WAV decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package wsd_pkg;
    localparam logic [31:0] TagRiff = 32'h4646_4952;
    localparam logic [31:0] TagWave = 32'h4556_4157;
    localparam logic [31:0] TagFmt  = 32'h2074_6D66;
    localparam logic [31:0] TagData = 32'h6174_6164;
    localparam logic signed [24:0] QMax = 25'sh0FF_FFFF;
    localparam logic signed [24:0] QMin = -25'sh100_0000;

    typedef enum logic [7:0] {
        PH_RIFF = 8'b0000_0001,
        PH_CHDR = 8'b0000_0010,
        PH_FMT  = 8'b0000_0100,
        PH_SKIP = 8'b0000_1000,
        PH_PAD  = 8'b0001_0000,
        PH_DATA = 8'b0010_0000,
        PH_DONE = 8'b0100_0000,
        PH_HALT = 8'b1000_0000
    } t_phase;

    typedef enum logic [3:0] {
        ERR_RIFF     = 4'd0,
        ERR_SHORTFMT = 4'd1,
        ERR_FORMAT   = 4'd2,
        ERR_CHAN     = 4'd3,
        ERR_NOFMT    = 4'd4,
        ERR_DEPTH    = 4'd5,
        ERR_ODD      = 4'd6,
        ERR_NODATA   = 4'd7,
        ERR_TRUNC    = 4'd8
    } t_err;

    typedef struct packed {
        logic        kind;
        logic [24:0] sample;
        logic        last;
        logic [3:0]  code;
    } t_result;
endpackage
`default_nettype wire

/* rtl/core/wsd_float_q24.sv */
// ----------------------------------------------------------------------------
// wsd_float_q24: float32 to Q1.24
// Rounds half away from zero, saturates, and flushes NaN and subnormals to 0.
// ----------------------------------------------------------------------------
`default_nettype none
module wsd_float_q24 (
    input  wire logic [31:0] i_f,
    output logic      [24:0] o_q
);
    logic [7:0]  e;
    logic [23:0] mant;
    logic [7:0]  r;
    logic [24:0] mag;
    logic [24:0] rnd;
    logic        neg;

    always_comb begin
        e    = i_f[30:23];
        neg  = i_f[31];
        mant = {1'b1, i_f[22:0]};
        r    = 8'd126 - e;
        rnd  = '0;
        if (r != 8'd0 && r <= 8'd25) rnd = 25'd1 << (r - 8'd1);
        mag  = ({1'b0, mant} + rnd) >> r;
        if (e == 8'd0 || (e == 8'hFF && i_f[22:0] != 23'd0)) o_q = '0;
        else if (e >= 8'd127) o_q = neg ? wsd_pkg::QMin : wsd_pkg::QMax;
        else if (r > 8'd25) o_q = '0;
        else o_q = neg ? 25'(-mag) : mag;
    end
endmodule
`default_nettype wire

/* rtl/core/wav_stream_decoder_unit.sv */
// ----------------------------------------------------------------------------
// wav_stream_decoder_unit: streaming RIFF/WAVE PCM decoder
// Parses a WAV byte stream and gives Q1.24 mono samples or error results.
// ----------------------------------------------------------------------------
// A result is registered on the clock edge that accepts the byte that causes it.
// Throughput: one byte per cycle while the output register is free or being drained.
// The output register is a single stage; a stalled result holds the input.
// Reset (synchronous, active low) returns the parser to the RIFF header.
`default_nettype none
module wav_stream_decoder_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // end_of_file
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [24:0] sample, [28:25] error_code,
                                             // [60:29] sample_rate, rest zero
    output logic             m_axis_tuser,   // kind
    output logic             m_axis_tlast    // last_sample
);
    wsd_pkg::t_phase r_ph, n_ph;
    logic [31:0] r_pos, n_pos, r_tag, n_tag, r_len, n_len, r_rate, n_rate, r_asm, n_asm;
    logic [31:0] r_rem, n_rem;
    logic [15:0] r_fmt, n_fmt, r_ch, n_ch, r_bits, n_bits;
    logic        r_seen, n_seen, r_rt, n_rt;
    logic [24:0] r_left, n_left;
    logic        r_ov, n_ov;
    wsd_pkg::t_result r_res, n_res;
    logic [31:0] r_orate, n_orate;

    logic        acc;
    logic [7:0]  b;
    logic [4:0]  sh;
    logic [31:0] bw, asm_now, total, frames, pos1;
    logic [24:0] fq, v, dec;
    logic [25:0] ssum;
    logic        got, fmt_ok, ch_ok, depth_ok;
    logic [31:0] sk_len;
    logic        sk_pad;

    wsd_float_q24 u_fq (.i_f(asm_now), .o_q(fq));

    assign s_axis_tready = !r_ov || m_axis_tready;
    assign acc = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_res.kind;
    assign m_axis_tlast  = r_res.last;
    assign m_axis_tdata  = {3'd0, r_orate, r_res.code, r_res.sample};

    always_comb begin
        b = s_axis_tdata;
        sh = {r_pos[1:0], 3'd0};
        bw = 32'(b) << sh;
        asm_now = r_asm | bw;
        pos1 = r_pos + 32'd1;
        n_ph = r_ph; n_pos = r_pos; n_tag = r_tag; n_len = r_len; n_rate = r_rate;
        n_asm = r_asm; n_rem = r_rem; n_fmt = r_fmt; n_ch = r_ch; n_bits = r_bits;
        n_seen = r_seen; n_rt = r_rt; n_left = r_left;
        n_res = r_res; n_orate = r_orate;
        got = 1'b0;
        sk_len = '0; sk_pad = 1'b0;
        total = '0; frames = '0; dec = '0; v = '0; ssum = '0;
        fmt_ok = 1'b0; ch_ok = 1'b0; depth_ok = 1'b0;
        case (r_ph)
            wsd_pkg::PH_RIFF: begin
                if (r_pos < 32'd4 || r_pos >= 32'd8) n_tag = r_tag | bw;
                if (r_pos == 32'd3) begin
                    n_tag = '0;
                    n_pos = pos1;
                    if ((r_tag | bw) != wsd_pkg::TagRiff) begin
                        got = 1'b1; n_res = '{1'b1, '0, 1'b0, wsd_pkg::ERR_RIFF};
                        n_ph = wsd_pkg::PH_HALT;
                    end
                end else if (r_pos == 32'd11) begin
                    if ((r_tag | bw) != wsd_pkg::TagWave) begin
                        got = 1'b1; n_res = '{1'b1, '0, 1'b0, wsd_pkg::ERR_RIFF};
                        n_ph = wsd_pkg::PH_HALT;
                    end else begin
                        n_ph = wsd_pkg::PH_CHDR; n_pos = '0; n_tag = '0; n_len = '0;
                    end
                end else n_pos = pos1;
            end
            wsd_pkg::PH_CHDR: begin
                if (r_pos < 32'd4) n_tag = r_tag | bw;
                else n_len = r_len | bw;
                n_pos = pos1;
                if (r_pos == 32'd7) begin
                    depth_ok = (r_fmt == 16'd1 && (r_bits == 16'd16 || r_bits == 16'd24))
                            || (r_fmt == 16'd3 && r_bits == 16'd32);
                    case (r_bits)
                        16'd16:  total = n_len >> 1;
                        16'd24:  total = 32'((64'(n_len) * 64'hAAAA_AAAB) >> 33);
                        default: total = n_len >> 2;
                    endcase
                    frames = (r_ch == 16'd2) ? (total >> 1) : total;
                    if (r_tag == wsd_pkg::TagFmt) begin
                        if (n_len < 32'd16) begin
                            got = 1'b1; n_res = '{1'b1, '0, 1'b0, wsd_pkg::ERR_SHORTFMT};
                            n_ph = wsd_pkg::PH_HALT;
                        end else begin
                            n_ph = wsd_pkg::PH_FMT; n_pos = '0;
                            n_fmt = '0; n_ch = '0; n_rate = '0; n_bits = '0;
                        end
                    end else if (r_tag == wsd_pkg::TagData) begin
                        got = 1'b1; n_ph = wsd_pkg::PH_HALT;
                        if (!r_seen) n_res = '{1'b1, '0, 1'b0, wsd_pkg::ERR_NOFMT};
                        else if (!depth_ok) n_res = '{1'b1, '0, 1'b0, wsd_pkg::ERR_DEPTH};
                        else if (r_ch == 16'd2 && total[0])
                            n_res = '{1'b1, '0, 1'b0, wsd_pkg::ERR_ODD};
                        else if (frames == 32'd0)
                            n_res = '{1'b1, '0, 1'b0, wsd_pkg::ERR_NODATA};
                        else begin
                            got = 1'b0; n_rem = frames; n_ph = wsd_pkg::PH_DATA;
                            n_pos = '0; n_asm = '0; n_rt = 1'b0;
                        end
                    end else begin
                        sk_len = n_len; sk_pad = n_len[0];
                        n_len = sk_len; n_pos = {31'd0, sk_pad};
                        if (sk_len != 32'd0) n_ph = wsd_pkg::PH_SKIP;
                        else if (sk_pad) n_ph = wsd_pkg::PH_PAD;
                        else begin
                            n_ph = wsd_pkg::PH_CHDR; n_pos = '0; n_tag = '0; n_len = '0;
                        end
                    end
                end
            end
            wsd_pkg::PH_FMT: begin
                if (r_pos < 32'd2) n_fmt = r_fmt | 16'(bw);
                else if (r_pos < 32'd4) n_ch = r_ch | (16'(b) << {r_pos[0] ^ 1'b0, 3'd0});
                else if (r_pos < 32'd8) n_rate = r_rate | bw;
                else if (r_pos >= 32'd14) n_bits = r_bits | (16'(b) << {r_pos[0], 3'd0});
                n_pos = pos1;
                if (r_pos == 32'd15) begin
                    fmt_ok = (r_fmt == 16'd1 || r_fmt == 16'd3);
                    ch_ok = (r_ch == 16'd1 || r_ch == 16'd2);
                    if (!fmt_ok) begin
                        got = 1'b1; n_res = '{1'b1, '0, 1'b0, wsd_pkg::ERR_FORMAT};
                        n_ph = wsd_pkg::PH_HALT;
                    end else if (!ch_ok) begin
                        got = 1'b1; n_res = '{1'b1, '0, 1'b0, wsd_pkg::ERR_CHAN};
                        n_ph = wsd_pkg::PH_HALT;
                    end else begin
                        n_seen = 1'b1;
                        sk_len = r_len - 32'd16; sk_pad = r_len[0];
                        n_len = sk_len; n_pos = {31'd0, sk_pad};
                        if (sk_len != 32'd0) n_ph = wsd_pkg::PH_SKIP;
                        else if (sk_pad) n_ph = wsd_pkg::PH_PAD;
                        else begin
                            n_ph = wsd_pkg::PH_CHDR; n_pos = '0; n_tag = '0; n_len = '0;
                        end
                    end
                end
            end
            wsd_pkg::PH_SKIP: begin
                n_len = r_len - 32'd1;
                if (n_len == 32'd0) begin
                    if (r_pos[0]) begin
                        n_ph = wsd_pkg::PH_PAD; n_pos = 32'd1;
                    end else begin
                        n_ph = wsd_pkg::PH_CHDR; n_pos = '0; n_tag = '0; n_len = '0;
                    end
                end
            end
            wsd_pkg::PH_PAD: begin
                n_ph = wsd_pkg::PH_CHDR; n_pos = '0; n_tag = '0; n_len = '0;
            end
            wsd_pkg::PH_DATA: begin
                n_asm = asm_now; n_pos = pos1;
                if (pos1 >= 32'(r_bits[15:3])) begin
                    case (r_bits)
                        16'd16:  dec = {asm_now[15:0], 9'd0};
                        16'd24:  dec = {asm_now[23:0], 1'b0};
                        default: dec = fq;
                    endcase
                    n_pos = '0; n_asm = '0;
                    if (r_ch == 16'd2 && !r_rt) begin
                        n_left = dec; n_rt = 1'b1;
                    end else begin
                        ssum = {r_left[24], r_left} + {dec[24], dec};
                        v = (r_ch == 16'd2) ? ssum[25:1] : dec;
                        n_rt = 1'b0;
                        n_rem = r_rem - 32'd1;
                        got = 1'b1;
                        n_res = '{1'b0, v, n_rem == 32'd0, wsd_pkg::ERR_RIFF};
                        if (n_rem == 32'd0) n_ph = wsd_pkg::PH_DONE;
                    end
                end
            end
            default: ;
        endcase
        n_orate = n_rate;
        if (s_axis_tlast) begin
            if (got && !n_res.kind && n_ph == wsd_pkg::PH_DATA)
                n_res = '{1'b1, '0, 1'b0, wsd_pkg::ERR_TRUNC};
            else if (!got) begin
                got = 1'b1;
                case (n_ph)
                    wsd_pkg::PH_RIFF: n_res = '{1'b1, '0, 1'b0, wsd_pkg::ERR_RIFF};
                    wsd_pkg::PH_CHDR, wsd_pkg::PH_SKIP, wsd_pkg::PH_PAD:
                        n_res = '{1'b1, '0, 1'b0, wsd_pkg::ERR_NODATA};
                    wsd_pkg::PH_FMT:  n_res = '{1'b1, '0, 1'b0, wsd_pkg::ERR_SHORTFMT};
                    wsd_pkg::PH_DATA: n_res = '{1'b1, '0, 1'b0, wsd_pkg::ERR_TRUNC};
                    default: got = 1'b0;
                endcase
            end
            n_ph = wsd_pkg::PH_RIFF; n_pos = '0; n_tag = '0; n_len = '0;
            n_fmt = '0; n_ch = '0; n_rate = '0; n_bits = '0; n_seen = 1'b0;
            n_asm = '0; n_left = '0; n_rt = 1'b0; n_rem = '0;
        end
        n_ov = r_ov && !m_axis_tready;
        if (acc && got) n_ov = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= wsd_pkg::PH_RIFF;
            r_pos <= '0; r_tag <= '0; r_len <= '0; r_rate <= '0; r_asm <= '0;
            r_rem <= '0; r_fmt <= '0; r_ch <= '0; r_bits <= '0;
            r_seen <= 1'b0; r_rt <= 1'b0; r_left <= '0; r_ov <= 1'b0;
        end else begin
            r_ov <= n_ov;
            if (acc) begin
                r_ph <= n_ph; r_pos <= n_pos; r_tag <= n_tag; r_len <= n_len;
                r_rate <= n_rate; r_asm <= n_asm; r_rem <= n_rem; r_fmt <= n_fmt;
                r_ch <= n_ch; r_bits <= n_bits; r_seen <= n_seen; r_rt <= n_rt;
                r_left <= n_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && got) begin
            r_res <= n_res;
            r_orate <= n_orate;
        end
    end
endmodule
`default_nettype wire

/* rtl/core/wsd_checker.sv */
// ----------------------------------------------------------------------------
// wsd_checker: port-level checks for the WAV decoder
// Watches the stream ports and flags handshake and result-format slips.
// ----------------------------------------------------------------------------
`default_nettype none
module wsd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic        m_axis_tuser,
    input wire logic        m_axis_tlast
);
    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");
    // The input is ready whenever the output register is free.
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready) else $error("ready low with empty output");
    // Error results carry no sample and no last flag.
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[24:0] == 25'd0 && !m_axis_tlast)
        else $error("error result with sample bits");
    // Sample results carry a zero code.
    a_smp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[28:25] == 4'd0)
        else $error("sample result with code");
endmodule

bind wav_stream_decoder_unit wsd_checker u_wsd_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast));
`default_nettype wire

/* bench/wav_stream_decoder_unit_tb.sv */
// ----------------------------------------------------------------------------
// wav_stream_decoder_unit_tb: self-checking bench for the WAV stream decoder
// Feeds directed and random WAV byte streams, predicts every sample and error
// beat in the bench itself and compares them with the block's output stream.
// ----------------------------------------------------------------------------
`default_nettype none

class wav_result_board;
    typedef struct {
        logic        kind;
        logic [24:0] sample;
        logic        last;
        logic [3:0]  code;
        logic [31:0] rate;
    } t_beat;

    t_beat       pending[$];
    int unsigned errors;

    // Decoder state, mirrored from the block's behavior.
    wsd_pkg::t_phase phase;
    logic [31:0] pos, tag, clen, fmt_code, chans, rate, bits, asm_word;
    logic        fmt_ok, right_turn;
    logic signed [24:0] left_hold;
    logic [31:0] remaining;

    function new();
        errors = 0;
        clear();
    endfunction

    function void clear();
        phase = wsd_pkg::PH_RIFF;
        pos = 0; tag = 0; clen = 0; fmt_code = 0; chans = 0; rate = 0; bits = 0;
        asm_word = 0; fmt_ok = 0; right_turn = 0; left_hold = 0; remaining = 0;
    endfunction

    function void push(logic kind, logic [24:0] s, logic last, logic [3:0] code);
        t_beat b;
        b.kind = kind; b.sample = s; b.last = last; b.code = code; b.rate = rate;
        pending.push_back(b);
    endfunction

    function void fail_with(wsd_pkg::t_err code);
        push(1'b1, '0, 1'b0, code);
        phase = wsd_pkg::PH_HALT;
    endfunction

    function void enter_skip(logic [31:0] count, logic pad);
        clen = count;
        pos = {31'd0, pad};
        if (count != 0) phase = wsd_pkg::PH_SKIP;
        else phase = pad ? wsd_pkg::PH_PAD : wsd_pkg::PH_CHDR;
        if (phase == wsd_pkg::PH_CHDR) begin
            pos = 0; tag = 0; clen = 0;
        end
    endfunction

    function logic signed [24:0] float_to_fixed(logic [31:0] f);
        logic [7:0]  e;
        logic [31:0] mant, mag, r;
        e = f[30:23];
        if (e == 8'hFF && f[22:0] != 0) return '0;
        if (e == 0) return '0;
        if (e >= 127) return f[31] ? wsd_pkg::QMin : wsd_pkg::QMax;
        mant = {8'd0, 1'b1, f[22:0]};
        r = 126 - e;
        if (r > 25) return '0;
        mag = (r == 0) ? mant : ((mant + (32'd1 << (r - 1))) >> r);
        return f[31] ? -$signed(mag[24:0]) : $signed(mag[24:0]);
    endfunction

    function logic signed [24:0] decode_word();
        if (bits == 16) return $signed({asm_word[15:0], 9'd0});
        if (bits == 24) return $signed({asm_word[23:0], 1'b0});
        return float_to_fixed(asm_word);
    endfunction

    function void open_chunk();
        logic [31:0] total, frames;
        if (tag == wsd_pkg::TagFmt) begin
            if (clen < 16) begin fail_with(wsd_pkg::ERR_SHORTFMT); return; end
            phase = wsd_pkg::PH_FMT; pos = 0;
            fmt_code = 0; chans = 0; rate = 0; bits = 0;
        end else if (tag == wsd_pkg::TagData) begin
            if (!fmt_ok) begin fail_with(wsd_pkg::ERR_NOFMT); return; end
            if (!((fmt_code == 1 && (bits == 16 || bits == 24)) ||
                  (fmt_code == 3 && bits == 32))) begin
                fail_with(wsd_pkg::ERR_DEPTH); return;
            end
            total = clen / (bits / 8);
            if (chans == 2 && total[0]) begin fail_with(wsd_pkg::ERR_ODD); return; end
            frames = (chans == 2) ? total / 2 : total;
            if (frames == 0) begin fail_with(wsd_pkg::ERR_NODATA); return; end
            remaining = frames; phase = wsd_pkg::PH_DATA;
            pos = 0; asm_word = 0; right_turn = 0;
        end else begin
            enter_skip(clen, clen[0]);
        end
    endfunction

    // Returns 1 when the byte produced a sample beat.
    function bit take_byte(logic [7:0] b);
        logic [31:0] sh, bw;
        logic signed [25:0] sum;
        logic signed [24:0] v;
        sh = 8 * pos[1:0];
        bw = {24'd0, b};
        case (phase)
            wsd_pkg::PH_RIFF: begin
                if (pos < 4 || pos >= 8) tag |= bw << sh;
                if (pos == 3 && tag != wsd_pkg::TagRiff) begin
                    fail_with(wsd_pkg::ERR_RIFF); return 0;
                end
                if (pos == 3) tag = 0;
                if (pos == 11) begin
                    if (tag != wsd_pkg::TagWave) fail_with(wsd_pkg::ERR_RIFF);
                    else begin
                        phase = wsd_pkg::PH_CHDR; pos = 0; tag = 0; clen = 0;
                    end
                    return 0;
                end
                pos++;
            end
            wsd_pkg::PH_CHDR: begin
                if (pos < 4) tag |= bw << sh;
                else clen |= bw << sh;
                if (pos == 7) open_chunk();
                else pos++;
            end
            wsd_pkg::PH_FMT: begin
                if (pos < 2) fmt_code |= bw << sh;
                else if (pos < 4) chans |= bw << (8 * (pos - 2) % 16);
                else if (pos < 8) rate |= bw << sh;
                else if (pos >= 14) bits |= bw << (8 * ((pos - 14) & 1));
                if (pos == 15) begin
                    if (fmt_code != 1 && fmt_code != 3) fail_with(wsd_pkg::ERR_FORMAT);
                    else if (chans < 1 || chans > 2) fail_with(wsd_pkg::ERR_CHAN);
                    else begin
                        fmt_ok = 1;
                        enter_skip(clen - 16, clen[0]);
                    end
                    return 0;
                end
                pos++;
            end
            wsd_pkg::PH_SKIP: begin
                clen--;
                if (clen == 0) enter_skip(0, pos[0]);
            end
            wsd_pkg::PH_PAD: enter_skip(0, 0);
            wsd_pkg::PH_DATA: begin
                asm_word |= bw << sh;
                pos++;
                if (pos < bits / 8) return 0;
                v = decode_word();
                pos = 0; asm_word = 0;
                if (chans == 2 && !right_turn) begin
                    left_hold = v; right_turn = 1; return 0;
                end
                if (chans == 2) begin
                    // Arithmetic shift gives the floor of the average.
                    sum = left_hold + v;
                    v = sum >>> 1;
                    right_turn = 0;
                end
                remaining--;
                push(1'b0, v, remaining == 0, '0);
                if (remaining == 0) phase = wsd_pkg::PH_DONE;
                return 1;
            end
            default: ;
        endcase
        return 0;
    endfunction

    function void note_byte(logic [7:0] b, logic eof);
        int unsigned depth_prior;
        bit got_sample;
        depth_prior = pending.size();
        got_sample = take_byte(b);
        if (eof) begin
            if (got_sample && phase == wsd_pkg::PH_DATA) begin
                // A sample that is not the last is replaced by truncation.
                void'(pending.pop_back());
                push(1'b1, '0, 1'b0, wsd_pkg::ERR_TRUNC);
            end else if (pending.size() == depth_prior) begin
                case (phase)
                    wsd_pkg::PH_RIFF: push(1'b1, '0, 1'b0, wsd_pkg::ERR_RIFF);
                    wsd_pkg::PH_CHDR, wsd_pkg::PH_SKIP, wsd_pkg::PH_PAD:
                        push(1'b1, '0, 1'b0, wsd_pkg::ERR_NODATA);
                    wsd_pkg::PH_FMT: push(1'b1, '0, 1'b0, wsd_pkg::ERR_SHORTFMT);
                    wsd_pkg::PH_DATA: push(1'b1, '0, 1'b0, wsd_pkg::ERR_TRUNC);
                    default: ;
                endcase
            end
            clear();
        end
    endfunction

    function void check_beat(logic [63:0] data, logic user, logic last);
        t_beat e;
        if (pending.size() == 0) begin
            $error("unexpected beat: data %h kind %0d", data, user);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (user !== e.kind) begin
            $error("kind: expected %0d, actual %0d", e.kind, user); errors++;
        end
        if (data[24:0] !== e.sample) begin
            $error("sample: expected %h, actual %h", e.sample, data[24:0]); errors++;
        end
        if (last !== e.last) begin
            $error("last_sample: expected %0d, actual %0d", e.last, last); errors++;
        end
        if (data[28:25] !== e.code) begin
            $error("error_code: expected %0d, actual %0d", e.code, data[28:25]); errors++;
        end
        if (data[60:29] !== e.rate) begin
            $error("sample_rate: expected %0d, actual %0d", e.rate, data[60:29]); errors++;
        end
        if (data[63:61] !== 3'd0) begin
            $error("padding: expected 0, actual %0d", data[63:61]); errors++;
        end
    endfunction
endclass

module wav_stream_decoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IdleLimit = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    wav_stream_decoder_unit u_top (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    wav_result_board board = new();
    logic [7:0]  file_bytes[$];
    int unsigned bytes_sent;
    int unsigned idle_cycles;
    bit          hold_off_req;
    bit          stall_pattern;

    // Receiver: own stall pattern, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    initial begin
        int unsigned mode_len;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off_req = 0;
            end
            mode_len = $urandom_range(1, 40);
            stall_pattern = $urandom_range(0, 2) != 0;
            repeat (mode_len) begin
                m_axis_tready <= stall_pattern ? ($urandom_range(0, 3) != 0) : 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IdleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Sends the queued file; the last byte carries tlast.
    task automatic send_file(bit bursty);
        int unsigned burst;
        int unsigned gap;
        burst = 0;
        while (file_bytes.size() != 0) begin
            if (bursty && burst == 0) begin
                gap = $urandom_range(0, 6);
                if (gap != 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst = $urandom_range(1, 30);
            end
            s_axis_tdata  <= file_bytes[0];
            s_axis_tlast  <= file_bytes.size() == 1;
            s_axis_tvalid <= 1'b1;
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
            board.note_byte(file_bytes[0], file_bytes.size() == 1);
            void'(file_bytes.pop_front());
            bytes_sent++;
            if (burst != 0) burst--;
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic put32(logic [31:0] w);
        for (int i = 0; i < 4; i++) file_bytes.push_back(w[8*i +: 8]);
    endtask

    task automatic put16(logic [15:0] w);
        file_bytes.push_back(w[7:0]);
        file_bytes.push_back(w[15:8]);
    endtask

    task automatic put_header();
        put32(wsd_pkg::TagRiff);
        put32($urandom);
        put32(wsd_pkg::TagWave);
    endtask

    task automatic put_fmt(logic [15:0] code, logic [15:0] ch, logic [31:0] rate,
                           logic [15:0] bits, logic [31:0] len);
        put32(wsd_pkg::TagFmt);
        put32(len);
        put16(code); put16(ch); put32(rate); put32($urandom); put16(16'($urandom));
        put16(bits);
        for (int i = 16; i < len; i++) file_bytes.push_back(8'($urandom));
        if (len[0]) file_bytes.push_back(8'($urandom));
    endtask

    task automatic put_data_samples(logic [15:0] code, logic [15:0] bits, int frames,
                                    int ch, int extra);
        logic [31:0] w;
        put32(wsd_pkg::TagData);
        put32(frames * ch * bits / 8 + extra);
        for (int i = 0; i < frames * ch; i++) begin
            w = $urandom;
            if (code == 3) begin
                case ($urandom_range(0, 5))
                    0: w[30:23] = 8'd255;
                    1: w[30:23] = 8'd0;
                    2: w[30:23] = 8'($urandom_range(96, 140));
                    default: w[30:23] = 8'($urandom_range(100, 126));
                endcase
            end
            for (int k = 0; k < bits / 8; k++) file_bytes.push_back(w[8*k +: 8]);
        end
    endtask

    // One random well-formed file, optionally cut short or with junk around.
    task automatic build_random_file();
        int kind, ch, frames, junk;
        logic [15:0] code, bits;
        kind = $urandom_range(0, 2);
        code = (kind == 2) ? 16'd3 : 16'd1;
        bits = (kind == 0) ? 16'd16 : (kind == 1) ? 16'd24 : 16'd32;
        ch = $urandom_range(1, 2);
        frames = $urandom_range(1, 12);
        put_header();
        if ($urandom_range(0, 2) == 0) begin
            junk = $urandom_range(0, 5);
            put32($urandom); put32(32'(junk));
            repeat (junk + junk % 2) file_bytes.push_back(8'($urandom));
        end
        put_fmt(code, 16'(ch), $urandom, bits,
                $urandom_range(0, 3) == 0 ? $urandom_range(16, 21) : 16);
        put_data_samples(code, bits, frames, ch, $urandom_range(0, 3) == 0 ? 1 : 0);
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 12)) void'(file_bytes.pop_back());
        else if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 4)) file_bytes.push_back(8'($urandom));
    endtask

    task automatic build_broken_file();
        case ($urandom_range(0, 7))
            0: repeat ($urandom_range(1, 14)) file_bytes.push_back(8'($urandom));
            1: begin
                put_header(); put_fmt(16'($urandom_range(0, 4)), 1, $urandom, 16, 16);
            end
            2: begin
                put_header(); put_fmt(1, 16'($urandom_range(0, 3)), $urandom, 16, 16);
            end
            3: begin put_header(); put32(wsd_pkg::TagFmt); put32($urandom_range(0, 15)); end
            4: begin put_header(); put_data_samples(1, 16, 2, 1, 0); end
            5: begin
                put_header(); put_fmt(16'($urandom_range(0, 1) ? 1 : 3), 1, $urandom,
                                      16'($urandom_range(0, 1) ? 8 : 32), 16);
                put_data_samples(1, 16, 1, 1, 0);
            end
            6: begin
                put_header(); put_fmt(1, 2, $urandom, 16, 16);
                put_data_samples(1, 16, 1, 1, 0);
            end
            default: begin
                put_header(); put_fmt(1, 1, $urandom, 24, 16);
                put32(wsd_pkg::TagData); put32($urandom_range(0, 2));
            end
        endcase
    endtask

    task automatic wait_drained();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int unsigned file_count;
        file_count = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed files: extreme PCM values, float specials, short files.
        put_header(); put_fmt(1, 1, 32'hFFFF_FFFF, 16, 16);
        put32(wsd_pkg::TagData); put32(8);
        put16(16'h7FFF); put16(16'h8000); put16(16'h0000); put16(16'hFFFF);
        send_file(0);
        put_header(); put_fmt(3, 2, 48000, 32, 18);
        put32(wsd_pkg::TagData); put32(24);
        put32(32'h7FC0_0000); put32(32'h0000_0001); put32(32'h3F80_0000);
        put32(32'hBF80_0000); put32(32'h3380_0000); put32(32'hB300_0000);
        send_file(0);
        put_header(); put_fmt(1, 2, 44100, 24, 16);
        put_data_samples(1, 24, 1, 2, 0);
        file_bytes.push_back(8'hFF);
        send_file(0);
        put32(wsd_pkg::TagRiff); file_bytes.push_back(8'h00);
        send_file(0);
        wait_drained();

        while (bytes_sent < 500) begin
            if ($urandom_range(0, 4) == 0) build_broken_file();
            else build_random_file();
            // The first file of this loop always runs into a long receiver hold-off.
            if (file_count == 0 || $urandom_range(0, 30) == 0) begin
                hold_off_req = 1;
            end
            file_count++;
            send_file($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 20) == 0) wait_drained();
        end

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

`default_nettype wire
